// ===== rtl/lpfu_pkg.sv =====
// lpfu_pkg: shared widths, constants and queue types for the field unpacker
// used by every rtl file of the unpacker but lpfu_checker; depends on nothing
`default_nettype none

package lpfu_pkg;

    localparam int WORD_W      = 64;
    localparam int SIZE_LSB    = 32;
    localparam int CODE_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 27;
    localparam int AVAIL_W     = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified word waiting for the back end
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_pop_t;

endpackage

`default_nettype wire

// ===== rtl/lpfu_if.sv =====
// lpfu_in_if / lpfu_out_if: valid-ready channels of the field unpacker
// depends on lpfu_pkg for the word width
`default_nettype none

interface lpfu_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpfu_pkg::WORD_W-1:0]   word;
    logic                          first;

    modport source (output valid, output word, output first, input ready);
    modport sink   (input valid, input word, input first, output ready);
endinterface

interface lpfu_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lpfu_pkg::WORD_W-1:0] value;
    logic                               run_last;
    logic                               stream_done;

    modport source (output valid, output value, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input value, input run_last, input stream_done,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/length_prefixed_field_unpacker.sv =====
// length_prefixed_field_unpacker: top level of the length-prefixed field unpacker
// depends on lpfu_pkg, lpfu_if, lpfu_front, lpfu_queue and lpfu_back
//
//  channel  dir  fields                          request accepted when
//  words    in   word[63:0], first               words.valid && words.ready
//  deltas   out  value[63:0] signed, run_last,   deltas.valid && deltas.ready
//                stream_done
//
// a word is loaded into the bit buffer, then each decoded field is taken as its code
// and then its payload (both through the one 128-bit buffer shifter), and the word
// is closed; a code whose payload spills into the next word is taken in the word
// that holds it; ignored and zero-size header words do not enter the run state
// rst_n clears all control state at once, no clearing pass
// a two-entry queue lets requests arrive while the back end works or stalls
// each result waits in a hold stage until its run_last flag is known, then
// moves to the output register; a stalled output stalls extraction only
`default_nettype none

module length_prefixed_field_unpacker (
    input  logic         clk,
    input  logic         rst_n,
    lpfu_in_if.sink      words,
    lpfu_out_if.source   deltas
);

    // front to queue
    lpfu_pkg::q_push_t push;
    logic              q_full;

    // queue to back end
    lpfu_pkg::q_pop_t  pop;
    logic              pop_ready;

    // classify requests, compute the value count of header words
    lpfu_front u_front (
        .words  (words),
        .q_full (q_full),
        .push   (push)
    );

    // decouples acceptance from extraction
    lpfu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // bit buffer, one code or payload per cycle while the output does not stall, hold and output stages
    lpfu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .deltas    (deltas)
    );

endmodule

`default_nettype wire

// ===== rtl/lpfu_front.sv =====
// lpfu_front: accepts input requests and classifies them for the queue
// depends on lpfu_pkg and lpfu_in_if
`default_nettype none

module lpfu_front (
    lpfu_in_if.sink            words,
    input  logic               q_full,
    output lpfu_pkg::q_push_t  push
);

    logic [lpfu_pkg::WORD_W-lpfu_pkg::SIZE_LSB:0] size_round;

    // ceil(size / 64) for header words
    assign size_round = {1'b0, words.word[lpfu_pkg::WORD_W-1:lpfu_pkg::SIZE_LSB]}
                        + (lpfu_pkg::WORD_W-lpfu_pkg::SIZE_LSB+1)'(lpfu_pkg::WORD_W - 1);

    assign words.ready       = !q_full;
    assign push.valid        = words.valid && !q_full;
    assign push.entry.word   = words.word;
    assign push.entry.first  = words.first;
    assign push.entry.count  = words.first
                               ? size_round[lpfu_pkg::WORD_W-lpfu_pkg::SIZE_LSB:6]
                               : '0;

endmodule

`default_nettype wire

// ===== rtl/lpfu_queue.sv =====
// lpfu_queue: short fifo between the front and the back end
// depends on lpfu_pkg
`default_nettype none

module lpfu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  lpfu_pkg::q_push_t  push,
    output logic               full,
    output lpfu_pkg::q_pop_t   pop,
    input  logic               pop_ready
);

    lpfu_pkg::entry_t                 slots [lpfu_pkg::QUEUE_DEPTH];
    logic [lpfu_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [lpfu_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [lpfu_pkg::QUEUE_AW:0]      fill_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full      = fill_reg == (lpfu_pkg::QUEUE_AW+1)'(lpfu_pkg::QUEUE_DEPTH);
    assign pop.valid = fill_reg != '0;
    assign pop.entry = slots[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop.valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpfu_back.sv =====
// lpfu_back: bit buffer, field extraction and result output stage
// depends on lpfu_pkg and lpfu_out_if
`default_nettype none

module lpfu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lpfu_pkg::q_pop_t  pop,
    output logic              pop_ready,
    lpfu_out_if.source        deltas
);

    localparam int W  = lpfu_pkg::WORD_W;
    localparam int AW = lpfu_pkg::AVAIL_W;
    localparam int LW = lpfu_pkg::LEN_W;
    localparam int CW = lpfu_pkg::CNT_W;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t          state_reg,      state_next;
    logic [W-1:0]    hi_reg,         hi_next;
    logic [W-1:0]    lo_reg,         lo_next;
    logic [AW-1:0]   avail_reg,      avail_next;
    logic [CW-1:0]   left_reg,       left_next;
    logic [LW-1:0]   pend_reg,       pend_next;
    logic            active_reg,     active_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [W-1:0]    hold_value_reg, hold_value_next;
    logic            hold_done_reg,  hold_done_next;
    logic            out_valid_reg,  out_valid_next;
    logic [W-1:0]    out_value_reg,  out_value_next;
    logic            out_last_reg,   out_last_next;
    logic            out_done_reg,   out_done_next;

    logic            can_emit;
    logic            no_field;
    logic [LW-1:0]   shamt;
    logic [2*W-1:0]  shifted;
    logic [2*W-1:0]  joined;
    logic [W-1:0]    v_raw;
    logic [W-1:0]    sign_mask;
    logic            sign_bit;

    assign pop_ready          = state_reg == ST_IDLE;
    assign can_emit           = !out_valid_reg || deltas.ready;
    assign deltas.valid       = out_valid_reg;
    assign deltas.value       = out_value_reg;
    assign deltas.run_last    = out_last_reg;
    assign deltas.stream_done = out_done_reg;

    // word loaded behind the held bits
    assign joined = {pop.entry.word, {W{1'b0}}} >> avail_reg[lpfu_pkg::CODE_W-1:0];

    // code or payload taken from the top of the buffer
    assign shamt   = (pend_reg == '0) ? LW'(lpfu_pkg::CODE_W) : pend_reg;
    assign shifted = {hi_reg, lo_reg} << shamt;

    assign v_raw     = hi_reg >> (LW'(W) - pend_reg);
    assign sign_bit  = v_raw[lpfu_pkg::CODE_W'(pend_reg - 1'b1)];
    assign sign_mask = {W{1'b1}} << pend_reg;

    assign no_field = (left_reg == '0)
                      || ((pend_reg == '0) && (avail_reg < AW'(lpfu_pkg::CODE_W)))
                      || ((pend_reg != '0) && (avail_reg < AW'(pend_reg)));

    always_comb
    begin
        state_next      = state_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        avail_next      = avail_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        active_next     = active_reg;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg && !deltas.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop.valid)
                begin
                    if (pop.entry.first)
                    begin
                        left_next  = pop.entry.count;
                        pend_next  = '0;
                        hi_next    = {pop.entry.word[lpfu_pkg::SIZE_LSB-1:0],
                                      {(W-lpfu_pkg::SIZE_LSB){1'b0}}};
                        lo_next    = '0;
                        avail_next = AW'(lpfu_pkg::SIZE_LSB);
                        if (pop.entry.count == '0)
                        begin
                            active_next = 1'b0;
                            hi_next     = '0;
                            avail_next  = '0;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            state_next  = ST_RUN;
                        end
                    end
                    else if (active_reg)
                    begin
                        hi_next    = hi_reg | joined[2*W-1:W];
                        lo_next    = joined[W-1:0];
                        avail_next = avail_reg + AW'(W);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (no_field)
                begin
                    // close the word; its last result leaves the hold stage flagged
                    if (!hold_valid_reg || can_emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_value_next  = hold_value_reg;
                            out_last_next   = 1'b1;
                            out_done_next   = hold_done_reg;
                            hold_valid_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                        if (left_reg == '0)
                        begin
                            active_next = 1'b0;
                            hi_next     = '0;
                            lo_next     = '0;
                            avail_next  = '0;
                            pend_next   = '0;
                        end
                    end
                end
                else if (pend_reg == '0)
                begin
                    pend_next  = LW'(hi_reg[W-1:W-lpfu_pkg::CODE_W]) + 1'b1;
                    hi_next    = shifted[2*W-1:W];
                    lo_next    = shifted[W-1:0];
                    avail_next = avail_reg - AW'(lpfu_pkg::CODE_W);
                end
                else if (!hold_valid_reg || can_emit)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = hold_value_reg;
                        out_last_next  = 1'b0;
                        out_done_next  = hold_done_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_value_next = sign_bit ? (v_raw | sign_mask) : v_raw;
                    hold_done_next  = left_reg == CW'(1);
                    left_next       = left_reg - 1'b1;
                    pend_next       = '0;
                    hi_next         = shifted[2*W-1:W];
                    lo_next         = shifted[W-1:0];
                    avail_next      = avail_reg - AW'(pend_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hi_reg         <= '0;
            lo_reg         <= '0;
            avail_reg      <= '0;
            left_reg       <= '0;
            pend_reg       <= '0;
            active_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            avail_reg      <= avail_next;
            left_reg       <= left_next;
            pend_reg       <= pend_next;
            active_reg     <= active_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_value_reg <= hold_value_next;
        hold_done_reg  <= hold_done_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lpfu_checker.sv =====
// lpfu_checker: port-level assertions on the unpacker output channel
// depends on length_prefixed_field_unpacker, to which it is bound
`default_nettype none

module lpfu_checker (
    input logic clk,
    input logic rst_n,
    input logic d_valid,
    input logic d_ready,
    input logic d_last,
    input logic d_done
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && !d_ready |=> d_valid)
        else $error("result dropped while stalled");

    // the end of a stream also ends the word's run
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && d_done |-> d_last)
        else $error("stream_done without run_last");

    // nothing is offered right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !d_valid)
        else $error("result offered out of reset");

endmodule

bind length_prefixed_field_unpacker lpfu_checker u_lpfu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_valid (deltas.valid),
    .d_ready (deltas.ready),
    .d_last  (deltas.run_last),
    .d_done  (deltas.stream_done)
);

`default_nettype wire
